>>> rtl/ste_pkg.sv
`default_nettype none

package ste_pkg;

   localparam int unsigned CsrIndexWidth = 2;

   localparam logic [CsrIndexWidth-1:0] CSR_CHAR_OFFSET   = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_XOR_KEY       = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_DEST_CAPACITY = 2'd2;

   localparam logic [7:0]  CHAR_OFFSET_RESET   = 8'h3c;
   localparam logic [7:0]  XOR_KEY_RESET       = 8'h00;
   localparam logic [15:0] DEST_CAPACITY_RESET = 16'hffff;

   localparam logic [1:0] PHASE_FIRST  = 2'd0;
   localparam logic [1:0] PHASE_SECOND = 2'd1;
   localparam logic [1:0] PHASE_THIRD  = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_final;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  code_char;
      logic        char_present;
      logic        end_of_message;
      logic [15:0] total_length;
   } rsp_payload_type;

endpackage

`default_nettype wire

>>> rtl/six_bit_text_encoder.sv
// The first result of an item is offered in the cycle after the item is accepted.
// An item gives at most two results; a byte that closes a group of three gives two characters
// while the capacity allows. A two-entry result buffer holds the results; a new item is taken
// as the last entry drains, or while the buffer is empty.
// Reset is synchronous and active high: it empties the buffer, clears the packing state and
// restores char_offset 0x3c, xor_key 0 and dest_capacity 65535.
`default_nettype none

module six_bit_text_encoder (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_ready,
   input  wire ste_pkg::req_payload_type req_payload,
   output logic                       rsp_valid,
   input  wire                        rsp_ready,
   output ste_pkg::rsp_payload_type   rsp_payload,
   input  wire                        csr_valid,
   output logic                       csr_ready,
   input  wire [ste_pkg::CsrIndexWidth-1:0] csr_index,
   input  wire [15:0]                 csr_wdata
);

   logic [7:0]  char_offset_ff;
   logic [7:0]  xor_key_ff;
   logic [15:0] dest_capacity_ff;

   logic [5:0]  leftover_ff, leftover_in;
   logic [1:0]  phase_ff, phase_in;
   logic [15:0] emitted_ff, emitted_in;

   ste_pkg::rsp_payload_type slot0_ff, slot1_ff;
   ste_pkg::rsp_payload_type res0, res1;
   logic [1:0]  fill_ff;
   logic [1:0]  res_count;

   logic [7:0]  x;
   logic [5:0]  made, rest;
   logic [15:0] e1, e2;
   logic        can_emit;
   logic        push, pop;

   assign csr_ready = 1'b1;
   assign rsp_valid = (fill_ff != 2'd0);
   assign rsp_payload = slot0_ff;
   assign req_ready = (fill_ff == 2'd0) || ((fill_ff == 2'd1) && rsp_ready);
   assign push = req_valid && req_ready;
   assign pop  = rsp_valid && rsp_ready;

   assign x  = req_payload.data_byte ^ xor_key_ff;
   assign e1 = emitted_ff + 16'd1;
   assign e2 = emitted_ff + 16'd2;
   assign can_emit = (emitted_ff < dest_capacity_ff);

   always_comb begin
      case (phase_ff)
         ste_pkg::PHASE_FIRST: begin
            made = x[7:2];
            rest = {x[1:0], 4'b0000};
         end
         ste_pkg::PHASE_SECOND: begin
            made = leftover_ff | {2'b00, x[7:4]};
            rest = {x[3:0], 2'b00};
         end
         default: begin
            made = leftover_ff | {4'b0000, x[7:6]};
            rest = x[5:0];
         end
      endcase
   end

   always_comb begin
      res0 = '0;
      res1 = '0;
      res_count = 2'd0;
      leftover_in = leftover_ff;
      phase_in = phase_ff;
      emitted_in = emitted_ff;
      if (can_emit) begin
         res0.code_char = {2'b00, made} + char_offset_ff;
         res0.char_present = 1'b1;
         res0.total_length = e1;
         res_count = 2'd1;
         emitted_in = e1;
         if (phase_ff == ste_pkg::PHASE_THIRD) begin
            leftover_in = 6'd0;
            phase_in = ste_pkg::PHASE_FIRST;
         end else begin
            leftover_in = rest;
            phase_in = phase_ff + 2'd1;
         end
         if ((e1 < dest_capacity_ff) &&
             ((phase_ff == ste_pkg::PHASE_THIRD) || req_payload.is_final)) begin
            res1.code_char = {2'b00, rest} + char_offset_ff;
            res1.char_present = 1'b1;
            res1.total_length = e2;
            res_count = 2'd2;
            emitted_in = e2;
         end
      end
      if (req_payload.is_final) begin
         if (res_count == 2'd0) begin
            res0.total_length = emitted_ff;
            res_count = 2'd1;
         end
         if (res_count == 2'd2) begin
            res1.end_of_message = 1'b1;
         end else begin
            res0.end_of_message = 1'b1;
         end
         leftover_in = 6'd0;
         phase_in = ste_pkg::PHASE_FIRST;
         emitted_in = 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_offset_ff <= ste_pkg::CHAR_OFFSET_RESET;
         xor_key_ff <= ste_pkg::XOR_KEY_RESET;
         dest_capacity_ff <= ste_pkg::DEST_CAPACITY_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ste_pkg::CSR_CHAR_OFFSET:   char_offset_ff <= csr_wdata[7:0];
            ste_pkg::CSR_XOR_KEY:       xor_key_ff <= csr_wdata[7:0];
            ste_pkg::CSR_DEST_CAPACITY: dest_capacity_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         leftover_ff <= 6'd0;
         phase_ff <= ste_pkg::PHASE_FIRST;
         emitted_ff <= 16'd0;
         fill_ff <= 2'd0;
      end else begin
         if (push) begin
            leftover_ff <= leftover_in;
            phase_ff <= phase_in;
            emitted_ff <= emitted_in;
            fill_ff <= res_count;
         end else if (pop) begin
            fill_ff <= fill_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot0_ff <= res0;
         slot1_ff <= res1;
      end else if (pop) begin
         slot0_ff <= slot1_ff;
      end
   end

endmodule

`default_nettype wire

>>> rtl/ste_checker.sv
`default_nettype none

module ste_checker (
   input wire                      clock,
   input wire                      reset,
   input wire                      req_ready,
   input wire ste_pkg::rsp_payload_type rsp_payload,
   input wire                      rsp_valid,
   input wire                      rsp_ready
);

   // A stalled result item must hold.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result item changed while stalled");

   // An item without a character only closes a message.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.char_present |->
         rsp_payload.end_of_message && (rsp_payload.code_char == 8'd0))
      else $error("empty result item is not an end item");

   // A character always counts itself in the length.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.char_present |-> rsp_payload.total_length != 16'd0)
      else $error("character item with zero length");

   // The block only refuses input while results are pending.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input refused with no result pending");

   // Reset empties the result buffer.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

endmodule

bind six_bit_text_encoder ste_checker u_ste_checker (
   .clock(clock),
   .reset(reset),
   .req_ready(req_ready),
   .rsp_payload(rsp_payload),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready)
);

`default_nettype wire

>>> tb/sv/six_bit_text_encoder_checker.sv
module six_bit_text_encoder_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  ste_pkg::req_payload_type req_payload,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  ste_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [ste_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [15:0]              csr_wdata,
   output int                       chars_outstanding,
   output int                       mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [7:0]  offset_q;
   logic [7:0]  key_q;
   logic [15:0] capacity_q;
   logic [15:0] emitted_q;
   logic [5:0]  leftover_q;
   logic [1:0]  phase_q;
   ste_pkg::rsp_payload_type pending_chars[$];

   task automatic push_char(input logic [5:0] code);
      ste_pkg::rsp_payload_type char_item;
      emitted_q = emitted_q + 16'd1;
      char_item.code_char      = {2'b00, code} + offset_q;
      char_item.char_present   = 1'b1;
      char_item.end_of_message = 1'b0;
      char_item.total_length   = emitted_q;
      pending_chars.push_back(char_item);
   endtask

   task automatic encode_byte(input ste_pkg::req_payload_type item);
      logic [7:0] x;
      logic [5:0] made;
      logic [5:0] rest;
      int produced;
      ste_pkg::rsp_payload_type tail;
      x = item.data_byte ^ key_q;
      produced = 0;
      if (emitted_q < capacity_q) begin
         case (phase_q)
            ste_pkg::PHASE_SECOND: begin
               made = leftover_q | {2'b00, x[7:4]};
               rest = {x[3:0], 2'b00};
            end
            ste_pkg::PHASE_THIRD: begin
               made = leftover_q | {4'b0000, x[7:6]};
               rest = x[5:0];
            end
            default: begin
               made = x[7:2];
               rest = {x[1:0], 4'b0000};
            end
         endcase
         push_char(made);
         produced++;
         if (phase_q == ste_pkg::PHASE_THIRD) begin
            if (emitted_q < capacity_q) begin
               push_char(rest);
               produced++;
            end
            leftover_q = '0;
            phase_q    = ste_pkg::PHASE_FIRST;
         end else begin
            leftover_q = rest;
            phase_q    = phase_q + 2'd1;
         end
      end
      if (item.is_final) begin
         if (phase_q != ste_pkg::PHASE_FIRST && emitted_q < capacity_q) begin
            push_char(leftover_q);
            produced++;
         end
         if (produced == 0) begin
            tail = '0;
            tail.end_of_message = 1'b1;
            tail.total_length   = emitted_q;
         end else begin
            tail = pending_chars.pop_back();
            tail.end_of_message = 1'b1;
         end
         pending_chars.push_back(tail);
         leftover_q = '0;
         phase_q    = ste_pkg::PHASE_FIRST;
         emitted_q  = '0;
      end
   endtask

   task automatic check_char(input ste_pkg::rsp_payload_type seen);
      ste_pkg::rsp_payload_type want;
      if (pending_chars.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("Unexpected result item: char %h present %b end %b length %0d",
                     seen.code_char, seen.char_present, seen.end_of_message,
                     seen.total_length);
      end else begin
         want = pending_chars.pop_front();
         if (seen.code_char !== want.code_char || seen.char_present !== want.char_present
             || seen.end_of_message !== want.end_of_message
             || seen.total_length !== want.total_length) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Result mismatch: expected char %h present %b end %b length %0d,",
                        want.code_char, want.char_present, want.end_of_message,
                        want.total_length,
                        " got char %h present %b end %b length %0d",
                        seen.code_char, seen.char_present, seen.end_of_message,
                        seen.total_length);
         end
      end
   endtask

   initial begin
      mismatch_count    = 0;
      chars_outstanding = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         offset_q   = ste_pkg::CHAR_OFFSET_RESET;
         key_q      = ste_pkg::XOR_KEY_RESET;
         capacity_q = ste_pkg::DEST_CAPACITY_RESET;
         emitted_q  = '0;
         leftover_q = '0;
         phase_q    = ste_pkg::PHASE_FIRST;
         pending_chars.delete();
      end else begin
         if (rsp_valid && rsp_ready)
            check_char(rsp_payload);
         if (req_valid && req_ready)
            encode_byte(req_payload);
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ste_pkg::CSR_CHAR_OFFSET:   offset_q   = csr_wdata[7:0];
               ste_pkg::CSR_XOR_KEY:       key_q      = csr_wdata[7:0];
               ste_pkg::CSR_DEST_CAPACITY: capacity_q = csr_wdata;
               default: ;
            endcase
         end
      end
      chars_outstanding <= pending_chars.size();
   end

endmodule

>>> tb/sv/six_bit_text_encoder_tb.sv
module six_bit_text_encoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [ste_pkg::CsrIndexWidth-1:0] CSR_UNUSED = 2'd3;

   typedef enum int {RX_ALWAYS, RX_HALF, RX_SPARSE, RX_TOGGLE} rx_mode_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   ste_pkg::req_payload_type req_payload;
   logic rsp_valid;
   logic rsp_ready;
   ste_pkg::rsp_payload_type rsp_payload;
   logic csr_valid;
   logic csr_ready;
   logic [ste_pkg::CsrIndexWidth-1:0] csr_index;
   logic [15:0] csr_wdata;
   int chars_outstanding;
   int mismatch_count;

   logic long_stall_go;
   logic long_stall_done;
   logic gapless;
   int   burst_left;

   six_bit_text_encoder dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   six_bit_text_encoder_checker char_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_payload       (req_payload),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_payload       (rsp_payload),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .chars_outstanding (chars_outstanding),
      .mismatch_count    (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("six_bit_text_encoder regression: fail");
      $finish;
   end

   initial begin : receiver
      rx_mode_type rx_mode;
      int span;
      int hold;
      rsp_ready = 1'b0;
      long_stall_done = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         span = $urandom_range(10, 80);
         repeat (span) begin
            if (long_stall_go && !long_stall_done) begin
               rsp_ready <= 1'b0;
               for (hold = 0; hold < 300; hold++) @(negedge clock);
               long_stall_done = 1'b1;
            end
            case (rx_mode)
               RX_ALWAYS: rsp_ready <= 1'b1;
               RX_HALF:   rsp_ready <= ($urandom_range(0, 1) == 1);
               RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
               default:   rsp_ready <= ~rsp_ready;
            endcase
            @(negedge clock);
         end
      end
   end

   task automatic send_byte(input logic [7:0] value, input logic last);
      ste_pkg::req_payload_type item;
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (!gapless && $urandom_range(0, 2) != 0) begin
            gap = $urandom_range(1, 8);
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      item.data_byte = value;
      item.is_final  = last;
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_message(input int len);
      int i;
      for (i = 0; i < len; i++)
         send_byte(8'($urandom_range(0, 255)), i == len - 1);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (chars_outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [ste_pkg::CsrIndexWidth-1:0] index,
                            input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic apply_config(input logic [7:0] offset, input logic [7:0] key,
                               input logic [15:0] capacity);
      logic [7:0] junk_hi;
      settle();
      junk_hi = 8'($urandom_range(0, 255));
      write_reg(ste_pkg::CSR_CHAR_OFFSET, {junk_hi, offset});
      junk_hi = 8'($urandom_range(0, 255));
      write_reg(ste_pkg::CSR_XOR_KEY, {junk_hi, key});
      write_reg(ste_pkg::CSR_DEST_CAPACITY, capacity);
      write_reg(CSR_UNUSED, 16'($urandom_range(0, 65535)));
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      int phase_idx;
      int sent;
      int len;
      logic [7:0] offset;
      logic [7:0] key;
      logic [15:0] capacity;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      long_stall_go = 1'b0;
      gapless = 1'b0;
      burst_left = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_byte(8'h00, 1'b1);
      send_byte(8'hff, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'hff, 1'b1);
      send_byte(8'ha5, 1'b0);
      send_byte(8'h5a, 1'b1);
      send_byte(8'h80, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'hfe, 1'b0);
      send_byte(8'h7f, 1'b1);
      apply_config(8'h4a, 8'd24, 16'hffff);
      send_byte(8'hc3, 1'b0);
      send_byte(8'h3c, 1'b0);
      send_byte(8'h99, 1'b0);
      send_byte(8'h66, 1'b1);
      apply_config(8'h3d, 8'd37, 16'd3);
      send_byte(8'h12, 1'b0);
      send_byte(8'h34, 1'b0);
      send_byte(8'h56, 1'b0);
      send_byte(8'h78, 1'b1);
      apply_config(8'hff, 8'hff, 16'd0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b1);
      apply_config(8'h00, 8'h00, 16'd2);
      send_byte(8'h11, 1'b0);
      send_byte(8'h22, 1'b1);
      apply_config(8'h3c, 8'h00, 16'd1);
      send_byte(8'h00, 1'b1);

      for (phase_idx = 0; phase_idx < 8; phase_idx++) begin
         case ($urandom_range(0, 5))
            0: begin key = 8'd0;  offset = 8'h3c; end
            1: begin key = 8'd24; offset = 8'h4a; end
            2: begin key = 8'd37; offset = 8'h3d; end
            3: begin key = 8'hff; offset = 8'hff; end
            4: begin key = 8'h00; offset = 8'h00; end
            default: begin
               key = 8'($urandom_range(0, 255));
               offset = 8'($urandom_range(0, 255));
            end
         endcase
         case ($urandom_range(0, 5))
            0, 1: capacity = 16'hffff;
            2: capacity = 16'd0;
            3: capacity = 16'($urandom_range(1, 6));
            4: capacity = 16'($urandom_range(7, 40));
            default: capacity = 16'($urandom_range(0, 65535));
         endcase
         if (phase_idx == 0 || phase_idx == 3)
            capacity = 16'hffff;
         apply_config(offset, key, capacity);
         if (phase_idx == 3) begin
            long_stall_go = 1'b1;
            gapless = 1'b1;
         end
         sent = 0;
         while (sent < 65) begin
            if ($urandom_range(0, 5) == 0)
               len = $urandom_range(20, 40);
            else
               len = $urandom_range(1, 12);
            send_message(len);
            sent += len;
         end
         gapless = 1'b0;
         settle();
      end

      settle();
      repeat (10) @(negedge clock);
      if (mismatch_count == 0)
         $display("six_bit_text_encoder regression: pass");
      else
         $display("six_bit_text_encoder regression: fail");
      $finish;
   end

endmodule

>>> sim.f
rtl/ste_pkg.sv
rtl/six_bit_text_encoder.sv
rtl/ste_checker.sv
tb/sv/six_bit_text_encoder_checker.sv
tb/sv/six_bit_text_encoder_tb.sv
